// File: rtl/iqfd_pkg.sv
// Shared types for the I/Q decimating FIR: request kinds passed from front to back.
package iqfd_pkg;

  localparam int KIND_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_TAP,
    KIND_SAMPLE,
    KIND_SAMPLE_EMIT
  } iqfd_kind_t;

endpackage

// File: rtl/iqfd_front.sv
// Front end: accepts requests, drops bad tap loads, tracks decimation phase, packs queue words.
module iqfd_front import iqfd_pkg::*; #(
  parameter int NUM_TAPS     = 127,
  parameter int DECIM_FACTOR = 4,
  parameter int SAMPLE_BITS  = 16,
  localparam int TW = $clog2(NUM_TAPS),
  localparam int PW = $clog2(DECIM_FACTOR),
  localparam int DW = KIND_W + 2 * SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          cmd,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_q,
  input  logic        [TW-1:0]          tap_index,
  input  logic signed [SAMPLE_BITS-1:0] tap_value,
  output logic                          push_valid,
  output logic        [DW-1:0]          push_data,
  input  logic                          push_full
);

  logic [PW-1:0]          phase;
  logic                   phase_last;
  logic                   accept;
  logic                   tap_bad;
  iqfd_kind_t             kind;
  logic [SAMPLE_BITS-1:0] word_a;
  logic [SAMPLE_BITS-1:0] word_b;

  assign phase_last = (phase == PW'(DECIM_FACTOR - 1));
  assign tap_bad    = cmd && ({1'b0, tap_index} >= (TW + 1)'(NUM_TAPS));
  assign push_valid = req_valid && !tap_bad;
  assign req_stall  = push_full;
  assign accept     = req_valid && !push_full;

  always_comb begin
    if (cmd) begin
      kind   = KIND_TAP;
      word_a = tap_value;
      word_b = SAMPLE_BITS'(tap_index);
    end else begin
      kind   = phase_last ? KIND_SAMPLE_EMIT : KIND_SAMPLE;
      word_a = sample_i;
      word_b = sample_q;
    end
  end

  assign push_data = {kind, word_a, word_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (accept && !cmd) begin
      phase <= phase_last ? '0 : phase + PW'(1);
    end
  end

endmodule

// File: rtl/iqfd_queue.sv
// Two-entry queue between the front end and the MAC back end.
module iqfd_queue #(
  parameter int WIDTH = 34
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_full,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data,
  input  logic             pop_stall
);

  localparam logic [1:0] FULL = 2'd2;

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       cnt;
  logic             do_push;
  logic             do_pop;

  assign push_full = (cnt == FULL);
  assign pop_valid = (cnt != '0);
  assign pop_data  = mem[rd_ptr];
  assign do_push   = push_valid && !push_full;
  assign do_pop    = pop_valid && !pop_stall;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// File: rtl/iqfd_back.sv
// Back end: tap and delay-line memories, one MAC per channel, scaling, saturation, output register.
module iqfd_back import iqfd_pkg::*; #(
  parameter int NUM_TAPS    = 127,
  parameter int LINE_DEPTH  = 128,
  parameter int SAMPLE_BITS = 16,
  localparam int TW   = $clog2(NUM_TAPS),
  localparam int LW   = $clog2(LINE_DEPTH),
  localparam int DW   = KIND_W + 2 * SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pop_valid,
  input  logic        [DW-1:0]          pop_data,
  output logic                          pop_stall,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic signed [SAMPLE_BITS-1:0] out_i,
  output logic signed [SAMPLE_BITS-1:0] out_q
);

  localparam int SB   = SAMPLE_BITS;
  localparam int FRAC = SB - 1;
  localparam int AW   = 2 * SB + TW;
  localparam int SW   = AW + FRAC;
  localparam int QW   = AW - FRAC;
  localparam logic signed [SW-1:0] BIAS = SW'((SW'(1) << (2 * FRAC)) - SW'(1));
  localparam logic signed [QW-1:0] QMAX = QW'((1 << FRAC) - 1);
  localparam logic signed [QW-1:0] QMIN = ~QMAX;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_SCALE,
    S_ROUND,
    S_EMIT
  } state_t;

  state_t state;

  iqfd_kind_t           kind;
  logic signed [SB-1:0] word_a;
  logic signed [SB-1:0] word_b;
  logic                 take;
  logic                 tap_we;
  logic                 line_we;

  logic signed [SB-1:0] tap_mem [NUM_TAPS];
  logic signed [SB-1:0] line_i  [LINE_DEPTH];
  logic signed [SB-1:0] line_q  [LINE_DEPTH];
  logic [LINE_DEPTH-1:0] line_vld;

  logic [LW-1:0] pos;
  logic [LW-1:0] pos_next;
  logic [LW-1:0] rd_idx;
  logic [LW-1:0] rd_idx_next;
  logic [TW-1:0] tap_cnt;

  logic signed [SB-1:0]   tap_rd;
  logic signed [SB-1:0]   smp_i_rd;
  logic signed [SB-1:0]   smp_q_rd;
  logic                   vld_rd;
  logic signed [SB-1:0]   smp_i_sel;
  logic signed [SB-1:0]   smp_q_sel;
  logic signed [2*SB-1:0] prod_i;
  logic signed [2*SB-1:0] prod_q;
  logic                   rd_act;
  logic                   mul_act;

  logic signed [AW-1:0] acc_i;
  logic signed [AW-1:0] acc_q;
  logic signed [SW-1:0] ext_i;
  logic signed [SW-1:0] ext_q;
  logic signed [SW-1:0] scale_i;
  logic signed [SW-1:0] scale_q;
  logic signed [SW-1:0] scl_i;
  logic signed [SW-1:0] scl_q;
  logic signed [SW-1:0] biased_i;
  logic signed [SW-1:0] biased_q;
  logic signed [QW-1:0] rnd_i;
  logic signed [QW-1:0] rnd_q;
  logic signed [SB-1:0] sat_i;
  logic signed [SB-1:0] sat_q;

  assign kind    = iqfd_kind_t'(pop_data[DW-1 -: KIND_W]);
  assign word_a  = pop_data[2*SB-1 -: SB];
  assign word_b  = pop_data[SB-1:0];
  assign take    = pop_valid && (state == S_IDLE);
  assign tap_we  = take && (kind == KIND_TAP);
  assign line_we = take && ((kind == KIND_SAMPLE) || (kind == KIND_SAMPLE_EMIT));
  assign pop_stall = (state != S_IDLE);

  assign pos_next    = (pos == LW'(LINE_DEPTH - 1)) ? '0 : pos + LW'(1);
  assign rd_idx_next = (rd_idx == '0) ? LW'(LINE_DEPTH - 1) : rd_idx - LW'(1);

  assign smp_i_sel = vld_rd ? smp_i_rd : '0;
  assign smp_q_sel = vld_rd ? smp_q_rd : '0;

  always_comb begin
    ext_i    = SW'(acc_i);
    ext_q    = SW'(acc_q);
    scale_i  = (ext_i <<< FRAC) - ext_i;
    scale_q  = (ext_q <<< FRAC) - ext_q;
    biased_i = scl_i + (scl_i[SW-1] ? BIAS : '0);
    biased_q = scl_q + (scl_q[SW-1] ? BIAS : '0);
    sat_i    = (rnd_i > QMAX) ? SB'(QMAX) : ((rnd_i < QMIN) ? SB'(QMIN) : SB'(rnd_i));
    sat_q    = (rnd_q > QMAX) ? SB'(QMAX) : ((rnd_q < QMIN) ? SB'(QMIN) : SB'(rnd_q));
  end

  always_ff @(posedge clk) begin
    if (tap_we) begin
      tap_mem[word_b[TW-1:0]] <= word_a;
    end
    if (line_we) begin
      line_i[pos] <= word_a;
      line_q[pos] <= word_b;
    end
    tap_rd   <= tap_mem[tap_cnt];
    smp_i_rd <= line_i[rd_idx];
    smp_q_rd <= line_q[rd_idx];
    vld_rd   <= line_vld[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_vld <= '0;
    end else if (line_we) begin
      line_vld[pos] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    prod_i <= (2*SB)'(tap_rd) * (2*SB)'(smp_i_sel);
    prod_q <= (2*SB)'(tap_rd) * (2*SB)'(smp_q_sel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pos          <= '0;
      rd_idx       <= '0;
      tap_cnt      <= '0;
      rd_act       <= 1'b0;
      mul_act      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      rd_act  <= (state == S_MAC);
      mul_act <= rd_act;
      if (mul_act) begin
        acc_i <= acc_i + AW'(prod_i);
        acc_q <= acc_q + AW'(prod_q);
      end
      if ((state == S_EMIT) && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (line_we) begin
            pos <= pos_next;
            if (kind == KIND_SAMPLE_EMIT) begin
              state   <= S_MAC;
              tap_cnt <= '0;
              rd_idx  <= pos;
              acc_i   <= '0;
              acc_q   <= '0;
            end
          end
        end
        S_MAC: begin
          tap_cnt <= tap_cnt + TW'(1);
          rd_idx  <= rd_idx_next;
          if (tap_cnt == TW'(NUM_TAPS - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_act && !mul_act) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          scl_i <= scale_i;
          scl_q <= scale_q;
          state <= S_ROUND;
        end
        S_ROUND: begin
          rnd_i <= biased_i[SW-1:2*FRAC];
          rnd_q <= biased_q[SW-1:2*FRAC];
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!result_valid || !result_stall) begin
            out_i <= sat_i;
            out_q <= sat_q;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/iq_fir_decimator_by_four.sv
// Top level: complex I/Q decimating FIR, front end, queue and MAC back end.
// A sample that completes a decimation group starts the tap walk; its result then passes the
// drain, scale, round and emit states to the output register. One MAC per channel walks the taps,
// and the back end takes no new queue word until that group's result is emitted.
// Reset: clears phase, write position, queue, output valid and delay-line valid bits, so the
// delay lines read as zero at once; taps stay undefined until loaded.
module iq_fir_decimator_by_four import iqfd_pkg::*; #(
  parameter int NUM_TAPS     = 127,
  parameter int LINE_DEPTH   = 128,
  parameter int DECIM_FACTOR = 4,
  parameter int SAMPLE_BITS  = 16,
  localparam int TW = $clog2(NUM_TAPS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          cmd,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_q,
  input  logic        [TW-1:0]          tap_index,
  input  logic signed [SAMPLE_BITS-1:0] tap_value,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic signed [SAMPLE_BITS-1:0] out_i,
  output logic signed [SAMPLE_BITS-1:0] out_q
);

  localparam int DW = KIND_W + 2 * SAMPLE_BITS;

  logic          push_valid;
  logic [DW-1:0] push_data;
  logic          push_full;
  logic          pop_valid;
  logic [DW-1:0] pop_data;
  logic          pop_stall;

  iqfd_front #(
    .NUM_TAPS    (NUM_TAPS),
    .DECIM_FACTOR(DECIM_FACTOR),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .sample_i  (sample_i),
    .sample_q  (sample_q),
    .tap_index (tap_index),
    .tap_value (tap_value),
    .push_valid(push_valid),
    .push_data (push_data),
    .push_full (push_full)
  );

  iqfd_queue #(
    .WIDTH(DW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_data (push_data),
    .push_full (push_full),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_stall (pop_stall)
  );

  iqfd_back #(
    .NUM_TAPS   (NUM_TAPS),
    .LINE_DEPTH (LINE_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_data    (pop_data),
    .pop_stall   (pop_stall),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .out_i       (out_i),
    .out_q       (out_q)
  );

endmodule

// File: rtl/iqfd_checker.sv
// Port-level checker for the I/Q decimating FIR and its bind to the top level.
module iqfd_checker #(
  parameter int DECIM_FACTOR = 4,
  parameter int SAMPLE_BITS  = 16,
  localparam int PW = $clog2(DECIM_FACTOR)
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_stall,
  input logic                          cmd,
  input logic                          result_valid,
  input logic                          result_stall,
  input logic signed [SAMPLE_BITS-1:0] out_i,
  input logic signed [SAMPLE_BITS-1:0] out_q
);

  localparam logic [2:0] OWED_MAX = 3'd4;

  logic [PW-1:0] phase;
  logic [2:0]    owed;
  logic          phase_last;
  logic          emit_req;
  logic          result_take;

  assign phase_last  = (phase == PW'(DECIM_FACTOR - 1));
  assign emit_req    = req_valid && !req_stall && !cmd && phase_last;
  assign result_take = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      owed  <= '0;
    end else begin
      if (req_valid && !req_stall && !cmd) begin
        phase <= phase_last ? '0 : phase + PW'(1);
      end
      owed <= owed + 3'(emit_req) - 3'(result_take);
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_result_owed: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (owed != '0))
    else $error("result without a completed decimation group");

  a_owed_bound: assert property (@(posedge clk) disable iff (rst) owed <= OWED_MAX)
    else $error("more pending results than queue and back end can hold");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> ($stable(out_i) && $stable(out_q)))
    else $error("stalled result changed");

endmodule

bind iq_fir_decimator_by_four iqfd_checker #(
  .DECIM_FACTOR(DECIM_FACTOR),
  .SAMPLE_BITS (SAMPLE_BITS)
) u_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req_valid),
  .req_stall   (req_stall),
  .cmd         (cmd),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .out_i       (out_i),
  .out_q       (out_q)
);
